>>> hw/rtl/tnsg_pkg.sv
// ----------------------------------------------------------------------------
// tnsg_pkg
// Types and constants shared by the tone and noise sound generator modules.
// ----------------------------------------------------------------------------
package tnsg_pkg;

	localparam int unsigned STEP_W  = 20;
	localparam int unsigned GAIN_W  = 8;
	localparam int unsigned MUTE_W  = 4;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned PER_W   = 32;
	localparam int unsigned CD_W    = 34;
	localparam int unsigned VOL_W   = 36;
	localparam int unsigned VOLF_W  = 20;
	localparam int unsigned LVL_W   = 15;
	localparam int unsigned SHIFT_W = 17;
	localparam int unsigned ACC_W   = 38;
	localparam int unsigned CH_N    = 4;

	localparam logic [STEP_W-1:0]  STEP_RESET   = 20'd12918;
	localparam logic [STEP_W-1:0]  STEP_MIN     = 20'd1024;
	localparam logic [31:0]        DEC_CONST    = 32'd4197201904;
	localparam logic [LVL_W-1:0]   LEVEL_MAX    = 15'd32767;
	localparam logic [SHIFT_W-1:0] FB_WHITE     = 17'h12000;
	localparam logic [SHIFT_W-1:0] FB_PERIODIC  = 17'h10000;
	localparam logic [3:0]         ATT_OFF      = 4'd15;

	localparam logic signed [CD_W-1:0]  ONE_SAMPLE = 34'sd65536;
	localparam logic signed [VOL_W-1:0] VOL_START  = -36'sd32768;
	localparam logic signed [21:0]      OUT_MAX    = 22'sd32767;
	localparam logic signed [21:0]      OUT_MIN    = -22'sd32767;

	// signed zeros so that compares stay signed
	localparam logic signed [CD_W-1:0]  CD_ZERO    = '0;
	localparam logic signed [ACC_W-1:0] ACC_ZERO   = '0;

	// sound register select codes carried in a latch byte
	localparam logic [2:0] REG_TONE0 = 3'd0;
	localparam logic [2:0] REG_TONE1 = 3'd2;
	localparam logic [2:0] REG_TONE2 = 3'd4;
	localparam logic [2:0] REG_NOISE = 3'd6;

	// noise rate that follows tone 2
	localparam logic [1:0] RATE_TONE2 = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_UPDATE_STEP = 2'd0;
	localparam logic [1:0] CFG_GAIN        = 2'd1;
	localparam logic [1:0] CFG_MUTE        = 2'd2;

	localparam logic [1:0] CH_TONE2 = 2'd2;
	localparam logic [1:0] CH_NOISE = 2'd3;

	typedef enum logic [2:0] {
		CMD_TONE_LO,
		CMD_TONE_HI,
		CMD_NOISE,
		CMD_ATTEN,
		CMD_SAMPLE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [1:0]       chan;
		logic [5:0]       data;
		logic             block_start;
		logic [LEN_W-1:0] block_length;
	} cmd_t;

	typedef struct packed {
		logic [STEP_W-1:0] update_step;
		logic [GAIN_W-1:0] gain;
		logic [MUTE_W-1:0] mute_mask;
	} cfg_t;

	typedef enum logic [1:0] {
		LVL_IDLE,
		LVL_ITER,
		LVL_SCALE,
		LVL_DONE
	} lvl_state_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_WRITE,
		E_LEVEL,
		E_PERIOD,
		E_ADVANCE,
		E_TONE_START,
		E_TONE_A,
		E_TONE_B,
		E_TONE_END,
		E_NOISE_A,
		E_NOISE_B,
		E_MIX,
		E_OUT
	} eng_state_t;

endpackage

>>> hw/rtl/tnsg_fifo.sv
// ----------------------------------------------------------------------------
// tnsg_fifo
// Small first-in first-out queue of register slots.
// ----------------------------------------------------------------------------
module tnsg_fifo #(
	parameter int unsigned WIDTH      = 25,
	parameter int unsigned DEPTH_LOG2 = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_ptr_q;
	logic [DEPTH_LOG2-1:0] rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == (DEPTH_LOG2+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> hw/rtl/tnsg_front.sv
// ----------------------------------------------------------------------------
// tnsg_front
// Accepts items, tracks the latched register and turns each item into a
// command for the back end.
// ----------------------------------------------------------------------------
module tnsg_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         req_type,
	input  logic [7:0]                   write_byte,
	input  logic                         block_start,
	input  logic [tnsg_pkg::LEN_W-1:0]   block_length,
	input  logic                         q_full,
	output logic                         q_push,
	output tnsg_pkg::cmd_t               q_cmd
);

	logic [2:0] latched_q;
	logic [2:0] reg_sel;
	logic       accept;

	assign full    = q_full;
	assign accept  = push && !q_full;
	assign q_push  = accept;
	assign reg_sel = write_byte[7] ? write_byte[6:4] : latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
		end else if (accept && !req_type && write_byte[7]) begin
			latched_q <= write_byte[6:4];
		end
	end

	always_comb begin
		q_cmd              = '0;
		q_cmd.block_start  = block_start;
		q_cmd.block_length = block_length;
		q_cmd.chan         = reg_sel[2:1];
		if (req_type) begin
			q_cmd.kind = tnsg_pkg::CMD_SAMPLE;
		end else begin
			unique case (reg_sel) inside
				tnsg_pkg::REG_TONE0, tnsg_pkg::REG_TONE1, tnsg_pkg::REG_TONE2: begin
					if (write_byte[7]) begin
						q_cmd.kind = tnsg_pkg::CMD_TONE_LO;
						q_cmd.data = {2'b00, write_byte[3:0]};
					end else begin
						q_cmd.kind = tnsg_pkg::CMD_TONE_HI;
						q_cmd.data = write_byte[5:0];
					end
				end
				tnsg_pkg::REG_NOISE: begin
					q_cmd.kind = tnsg_pkg::CMD_NOISE;
					q_cmd.data = {3'b000, write_byte[2:0]};
				end
				default: begin
					q_cmd.kind = tnsg_pkg::CMD_ATTEN;
					q_cmd.data = {2'b00, write_byte[3:0]};
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/tnsg_level.sv
// ----------------------------------------------------------------------------
// tnsg_level
// Iterative attenuation to level unit: one 0.2 dB decay multiply a cycle.
// ----------------------------------------------------------------------------
module tnsg_level (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [3:0]                  att,
	input  logic [tnsg_pkg::GAIN_W-1:0] gain,
	output logic                        done,
	output logic [tnsg_pkg::LVL_W-1:0]  level
);

	tnsg_pkg::lvl_state_t state_q;
	tnsg_pkg::lvl_state_t state_d;

	logic [31:0]                 r_q;
	logic [7:0]                  cnt_q;
	logic [tnsg_pkg::LVL_W-1:0]  level_q;
	logic [7:0]                  att_x10;
	logic signed [9:0]           e;
	logic [7:0]                  k;
	logic                        direct;
	logic [63:0]                 step_prod;
	logic [46:0]                 scale_prod;

	assign att_x10    = {1'b0, att, 3'b000} + {3'b000, att, 1'b0};
	assign e          = $signed({2'b00, gain}) - $signed({2'b00, att_x10});
	assign k          = 8'(-e);
	assign direct     = (att == tnsg_pkg::ATT_OFF) || (e >= 10'sd0);
	assign step_prod  = 64'(r_q) * 64'(tnsg_pkg::DEC_CONST);
	assign scale_prod = 47'(r_q) * 47'(tnsg_pkg::LEVEL_MAX);
	assign level      = level_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tnsg_pkg::LVL_IDLE:  if (start) state_d = direct ? tnsg_pkg::LVL_DONE
			                                                 : tnsg_pkg::LVL_ITER;
			tnsg_pkg::LVL_ITER:  if (cnt_q == '0) state_d = tnsg_pkg::LVL_SCALE;
			tnsg_pkg::LVL_SCALE: state_d = tnsg_pkg::LVL_DONE;
			tnsg_pkg::LVL_DONE:  state_d = tnsg_pkg::LVL_IDLE;
			default:             state_d = tnsg_pkg::LVL_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == tnsg_pkg::LVL_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnsg_pkg::LVL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// first decay step is the constant itself
	always_ff @(posedge clk) begin
		unique case (state_q)
			tnsg_pkg::LVL_IDLE: begin
				if (start) begin
					r_q   <= tnsg_pkg::DEC_CONST;
					cnt_q <= k - 8'd1;
					if (att == tnsg_pkg::ATT_OFF) level_q <= '0;
					else level_q <= tnsg_pkg::LEVEL_MAX;
				end
			end
			tnsg_pkg::LVL_ITER: begin
				if (cnt_q != '0) begin
					r_q   <= step_prod[63:32];
					cnt_q <= cnt_q - 8'd1;
				end
			end
			tnsg_pkg::LVL_SCALE: level_q <= scale_prod[46:32];
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/tnsg_engine.sv
// ----------------------------------------------------------------------------
// tnsg_engine
// Back end: applies register commands and renders one sample per request by
// stepping each square wave and, unless noise is muted, the noise shifter, then mixing.
// ----------------------------------------------------------------------------
module tnsg_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tnsg_pkg::cfg_t       cfg,
	input  tnsg_pkg::cmd_t       cmd,
	input  logic                 cmd_valid,
	output logic                 cmd_pop,
	output logic                 res_push,
	input  logic                 res_full,
	output logic [15:0]          res_sample
);

	tnsg_pkg::eng_state_t state_q;
	tnsg_pkg::eng_state_t state_d;

	// sound state
	logic [9:0]                         tone_q  [3];
	logic [1:0]                         rate_q;
	logic                               white_q;
	logic [tnsg_pkg::PER_W-1:0]         half_q  [tnsg_pkg::CH_N];
	logic signed [tnsg_pkg::CD_W-1:0]   cd_q    [tnsg_pkg::CH_N];
	logic [tnsg_pkg::CH_N-1:0]          wave_q;
	logic [tnsg_pkg::LVL_W-1:0]         level_q [tnsg_pkg::CH_N];
	logic [tnsg_pkg::SHIFT_W-1:0]       shift_q;

	// working registers
	tnsg_pkg::cmd_t                     cmd_q;
	logic [1:0]                         ch_q;
	logic [1:0]                         mix_q;
	logic signed [tnsg_pkg::VOL_W-1:0]  vol_q;
	logic signed [tnsg_pkg::CD_W-1:0]   left_q;
	logic signed [tnsg_pkg::VOLF_W-1:0] volf_q  [tnsg_pkg::CH_N];
	logic signed [tnsg_pkg::ACC_W-1:0]  acc_q;

	logic [tnsg_pkg::STEP_W-1:0]        tick;
	logic [29:0]                        per_prod;
	logic [tnsg_pkg::PER_W-1:0]         per_new;
	logic [tnsg_pkg::PER_W-1:0]         noise_half;
	logic signed [tnsg_pkg::CD_W-1:0]   span;
	logic signed [tnsg_pkg::CD_W-1:0]   cd_cur;
	logic signed [tnsg_pkg::CD_W-1:0]   per_cur;
	logic signed [tnsg_pkg::CD_W-1:0]   cd1;
	logic                               wave_cur;
	logic signed [tnsg_pkg::VOL_W-1:0]  vol_end;
	logic signed [tnsg_pkg::CD_W-1:0]   cd3;
	logic signed [tnsg_pkg::CD_W-1:0]   half3;
	logic signed [tnsg_pkg::CD_W-1:0]   ne;
	logic                               fired;
	logic [tnsg_pkg::SHIFT_W-1:0]       shift_pre;
	logic [tnsg_pkg::SHIFT_W-1:0]       shift_next;
	logic                               w_new;
	logic signed [tnsg_pkg::VOL_W-1:0]  vol_noise;
	logic signed [35:0]                 mix_prod;
	logic signed [tnsg_pkg::ACC_W-1:0]  acc_biased;
	logic signed [21:0]                 q_wide;
	logic                               lvl_start;
	logic                               lvl_done;
	logic [tnsg_pkg::LVL_W-1:0]         lvl_level;

	tnsg_level u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lvl_start),
		.att    (cmd_q.data[3:0]),
		.gain   (cfg.gain),
		.done   (lvl_done),
		.level  (lvl_level)
	);

	assign tick = (cfg.update_step < tnsg_pkg::STEP_MIN) ? tnsg_pkg::STEP_MIN
	                                                       : cfg.update_step;
	assign per_prod = 30'(tick) * 30'(tone_q[cmd_q.chan]);
	assign per_new  = (per_prod == '0) ? 32'(tick) : 32'(per_prod);

	always_comb begin
		case (cmd_q.data[1:0])
			2'd0:    noise_half = {7'b0, tick, 5'b0};
			2'd1:    noise_half = {6'b0, tick, 6'b0};
			2'd2:    noise_half = {5'b0, tick, 7'b0};
			default: noise_half = {half_q[2][30:0], 1'b0};
		endcase
	end

	assign span     = $signed({5'b0, cmd_q.block_length, 16'b0});
	assign cd_cur   = cd_q[ch_q];
	assign per_cur  = $signed({2'b00, half_q[ch_q]});
	assign wave_cur = wave_q[ch_q];
	assign cd1      = cd_cur + per_cur;
	assign vol_end  = wave_cur ? vol_q - tnsg_pkg::VOL_W'(cd_cur) : vol_q;

	// noise channel
	assign cd3        = cd_q[tnsg_pkg::CH_NOISE];
	assign half3      = $signed({2'b00, half_q[tnsg_pkg::CH_NOISE]});
	assign ne         = (cd3 < left_q) ? cd3 : left_q;
	assign fired      = (cd3 <= tnsg_pkg::CD_ZERO);
	assign shift_pre  = ((shift_q == '0) || shift_q[0])
	                  ? shift_q ^ (white_q ? tnsg_pkg::FB_WHITE : tnsg_pkg::FB_PERIODIC)
	                  : shift_q;
	assign shift_next = {1'b0, shift_pre[tnsg_pkg::SHIFT_W-1:1]};
	assign w_new      = fired ? shift_next[0] : wave_q[tnsg_pkg::CH_NOISE];
	// a reload adds and then removes the half period, leaving minus the old count
	assign vol_noise  = w_new ? vol_q - tnsg_pkg::VOL_W'(cd3) : vol_q;

	assign mix_prod   = volf_q[mix_q] * $signed({1'b0, level_q[mix_q]});
	assign acc_biased = acc_q + ((acc_q < tnsg_pkg::ACC_ZERO) ? 38'sd65535 : 38'sd0);
	assign q_wide     = 22'(acc_biased >>> 16);

	always_comb begin
		if (q_wide > tnsg_pkg::OUT_MAX) res_sample = 16'(tnsg_pkg::OUT_MAX);
		else if (q_wide < tnsg_pkg::OUT_MIN) res_sample = 16'(tnsg_pkg::OUT_MIN);
		else res_sample = q_wide[15:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tnsg_pkg::E_IDLE: begin
				if (cmd_valid) state_d = (cmd.kind == tnsg_pkg::CMD_SAMPLE)
				                         ? tnsg_pkg::E_ADVANCE : tnsg_pkg::E_WRITE;
			end
			tnsg_pkg::E_WRITE: begin
				case (cmd_q.kind)
					tnsg_pkg::CMD_NOISE: state_d = tnsg_pkg::E_IDLE;
					tnsg_pkg::CMD_ATTEN: state_d = tnsg_pkg::E_LEVEL;
					default:             state_d = tnsg_pkg::E_PERIOD;
				endcase
			end
			tnsg_pkg::E_LEVEL: begin
				if (lvl_done) state_d = (cmd_q.chan == tnsg_pkg::CH_NOISE)
				                        ? tnsg_pkg::E_IDLE : tnsg_pkg::E_PERIOD;
			end
			tnsg_pkg::E_PERIOD:     state_d = tnsg_pkg::E_IDLE;
			tnsg_pkg::E_ADVANCE:    state_d = tnsg_pkg::E_TONE_START;
			tnsg_pkg::E_TONE_START: state_d = tnsg_pkg::E_TONE_A;
			tnsg_pkg::E_TONE_A: begin
				if (cd_cur <= tnsg_pkg::CD_ZERO && cd1 <= tnsg_pkg::CD_ZERO)
					state_d = tnsg_pkg::E_TONE_B;
				else state_d = tnsg_pkg::E_TONE_END;
			end
			tnsg_pkg::E_TONE_B:     state_d = tnsg_pkg::E_TONE_A;
			tnsg_pkg::E_TONE_END: begin
				if (ch_q != tnsg_pkg::CH_TONE2) state_d = tnsg_pkg::E_TONE_START;
				else if (cfg.mute_mask[3]) state_d = tnsg_pkg::E_MIX;
				else state_d = tnsg_pkg::E_NOISE_A;
			end
			tnsg_pkg::E_NOISE_A:    state_d = tnsg_pkg::E_NOISE_B;
			tnsg_pkg::E_NOISE_B: begin
				state_d = (left_q > tnsg_pkg::CD_ZERO) ? tnsg_pkg::E_NOISE_A : tnsg_pkg::E_MIX;
			end
			tnsg_pkg::E_MIX: if (mix_q == 2'd3) state_d = tnsg_pkg::E_OUT;
			tnsg_pkg::E_OUT: if (!res_full) state_d = tnsg_pkg::E_IDLE;
			default:         state_d = tnsg_pkg::E_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop   = (state_q == tnsg_pkg::E_IDLE) && cmd_valid;
		lvl_start = (state_q == tnsg_pkg::E_WRITE) && (cmd_q.kind == tnsg_pkg::CMD_ATTEN);
		res_push  = (state_q == tnsg_pkg::E_OUT) && !res_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnsg_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sound state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) tone_q[i] <= '0;
			for (int i = 0; i < tnsg_pkg::CH_N; i++) begin
				half_q[i]  <= 32'(tnsg_pkg::STEP_RESET);
				cd_q[i]    <= $signed({14'b0, tnsg_pkg::STEP_RESET});
				level_q[i] <= '0;
			end
			wave_q  <= '0;
			rate_q  <= 2'd0;
			white_q <= 1'b1;
			shift_q <= '0;
		end else begin
			case (state_q)
				tnsg_pkg::E_WRITE: begin
					case (cmd_q.kind)
						tnsg_pkg::CMD_TONE_LO:
							tone_q[cmd_q.chan] <= {tone_q[cmd_q.chan][9:4], cmd_q.data[3:0]};
						tnsg_pkg::CMD_TONE_HI:
							tone_q[cmd_q.chan] <= {cmd_q.data[5:0], tone_q[cmd_q.chan][3:0]};
						tnsg_pkg::CMD_NOISE: begin
							rate_q  <= cmd_q.data[1:0];
							white_q <= cmd_q.data[2];
							shift_q <= '0;
							wave_q[tnsg_pkg::CH_NOISE] <= 1'b0;
							half_q[tnsg_pkg::CH_NOISE] <= noise_half;
						end
						default: ;
					endcase
				end
				tnsg_pkg::E_LEVEL: begin
					if (lvl_done) begin
						level_q[cmd_q.chan] <= cfg.mute_mask[cmd_q.chan] ? '0 : lvl_level;
					end
				end
				tnsg_pkg::E_PERIOD: begin
					half_q[cmd_q.chan] <= per_new;
					if (cmd_q.chan == tnsg_pkg::CH_TONE2 && rate_q == tnsg_pkg::RATE_TONE2) begin
						half_q[tnsg_pkg::CH_NOISE] <= {per_new[30:0], 1'b0};
					end
				end
				tnsg_pkg::E_ADVANCE: begin
					// silent channels are pushed past the block
					for (int i = 0; i < tnsg_pkg::CH_N; i++) begin
						if (cmd_q.block_start && level_q[i] == '0 && cd_q[i] <= span) begin
							cd_q[i] <= cd_q[i] + span;
						end
					end
				end
				tnsg_pkg::E_TONE_START: cd_q[ch_q] <= cd_cur - tnsg_pkg::ONE_SAMPLE;
				tnsg_pkg::E_TONE_A: begin
					if (cd_cur <= tnsg_pkg::CD_ZERO) begin
						cd_q[ch_q] <= cd1;
						if (cd1 > tnsg_pkg::CD_ZERO) wave_q[ch_q] <= !wave_cur;
					end
				end
				tnsg_pkg::E_TONE_B: cd_q[ch_q] <= cd_cur + per_cur;
				tnsg_pkg::E_NOISE_A: cd_q[tnsg_pkg::CH_NOISE] <= cd3 - ne;
				tnsg_pkg::E_NOISE_B: begin
					if (fired) begin
						shift_q <= shift_next;
						wave_q[tnsg_pkg::CH_NOISE] <= shift_next[0];
						cd_q[tnsg_pkg::CH_NOISE]   <= cd3 + half3;
					end
				end
				default: ;
			endcase
		end
	end

	// per sample working registers
	always_ff @(posedge clk) begin
		case (state_q)
			tnsg_pkg::E_IDLE: if (cmd_valid) cmd_q <= cmd;
			tnsg_pkg::E_ADVANCE: begin
				ch_q  <= 2'd0;
				mix_q <= 2'd0;
				acc_q <= '0;
				vol_q <= tnsg_pkg::VOL_START;
			end
			tnsg_pkg::E_TONE_START: begin
				if (wave_cur) vol_q <= vol_q + tnsg_pkg::VOL_W'(cd_cur);
			end
			tnsg_pkg::E_TONE_A: begin
				if (cd_cur <= tnsg_pkg::CD_ZERO && cd1 > tnsg_pkg::CD_ZERO && !wave_cur) begin
					vol_q <= vol_q + tnsg_pkg::VOL_W'(per_cur);
				end
			end
			tnsg_pkg::E_TONE_B: vol_q <= vol_q + tnsg_pkg::VOL_W'(per_cur);
			tnsg_pkg::E_TONE_END: begin
				volf_q[ch_q] <= vol_end[tnsg_pkg::VOLF_W-1:0];
				if (ch_q == tnsg_pkg::CH_TONE2) begin
					ch_q   <= tnsg_pkg::CH_NOISE;
					vol_q  <= '0;
					left_q <= tnsg_pkg::ONE_SAMPLE;
					volf_q[tnsg_pkg::CH_NOISE] <= '0;
				end else begin
					ch_q  <= ch_q + 2'd1;
					vol_q <= tnsg_pkg::VOL_START;
				end
			end
			tnsg_pkg::E_NOISE_A: begin
				if (wave_q[tnsg_pkg::CH_NOISE]) vol_q <= vol_q + tnsg_pkg::VOL_W'(cd3);
				left_q <= left_q - ne;
			end
			tnsg_pkg::E_NOISE_B: begin
				vol_q <= vol_noise;
				volf_q[tnsg_pkg::CH_NOISE] <= vol_noise[tnsg_pkg::VOLF_W-1:0];
			end
			tnsg_pkg::E_MIX: begin
				acc_q <= acc_q + tnsg_pkg::ACC_W'(mix_prod);
				mix_q <= mix_q + 2'd1;
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/tone_noise_sound_generator.sv
// ----------------------------------------------------------------------------
// tone_noise_sound_generator
// Three square-wave tones and one shift-register noise channel, driven by
// register write bytes, mixed to one saturated 16-bit sample per request.
//
//   channel   handshake            payload
//   input     push / full          req_type, write_byte, block_start, block_length
//   result    empty / pop          sample
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// In the back end a noise write byte sets the noise state, a tone write also reloads
// the half period, and an attenuation write waits for the level unit, which needs k
// decay multiplies, one a cycle, unless the channel is off or at full level. A sample
// steps each tone through every half-period pair and the noise through every step
// inside the sample; the noise steps are skipped when the noise channel is muted.
// Items queue ahead of the back end, so the input stalls only when that queue
// is full; finished samples wait in a result queue. No clearing pass after reset.
// ----------------------------------------------------------------------------
module tone_noise_sound_generator #(
	parameter int unsigned CMD_DEPTH_LOG2 = 2,
	parameter int unsigned RES_DEPTH_LOG2 = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic         req_type,
	input  logic [7:0]   write_byte,
	input  logic         block_start,
	input  logic [12:0]  block_length,
	output logic         empty,
	input  logic         pop,
	output logic signed [15:0] sample,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [19:0]  cfg_data
);

	tnsg_pkg::cfg_t cfg_q;
	tnsg_pkg::cmd_t front_cmd;
	tnsg_pkg::cmd_t cmd_head;
	logic           front_push;
	logic           cmd_full;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           res_push;
	logic           res_full;
	logic [15:0]    res_sample;
	logic [15:0]    res_head;

	assign cfg_ready = 1'b1;
	assign sample    = $signed(res_head);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.update_step <= tnsg_pkg::STEP_RESET;
			cfg_q.gain        <= '0;
			cfg_q.mute_mask   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tnsg_pkg::CFG_UPDATE_STEP: cfg_q.update_step <= cfg_data;
				tnsg_pkg::CFG_GAIN:        cfg_q.gain        <= cfg_data[7:0];
				tnsg_pkg::CFG_MUTE:        cfg_q.mute_mask   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	tnsg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.write_byte   (write_byte),
		.block_start  (block_start),
		.block_length (block_length),
		.q_full       (cmd_full),
		.q_push       (front_push),
		.q_cmd        (front_cmd)
	);

	tnsg_fifo #(
		.WIDTH      ($bits(tnsg_pkg::cmd_t)),
		.DEPTH_LOG2 (CMD_DEPTH_LOG2)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_cmd),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	tnsg_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd_head),
		.cmd_valid  (!cmd_empty),
		.cmd_pop    (cmd_pop),
		.res_push   (res_push),
		.res_full   (res_full),
		.res_sample (res_sample)
	);

	tnsg_fifo #(
		.WIDTH      (16),
		.DEPTH_LOG2 (RES_DEPTH_LOG2)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_sample),
		.rd_en   (pop),
		.rd_data (res_head),
		.full    (res_full),
		.empty   (empty)
	);

`ifndef NO_ASSERTIONS
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command taken from an empty queue");

	a_sample_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (res_head != 16'h8000))
		else $error("sample outside saturation range");

	a_item_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> front_push)
		else $error("accepted item not queued");
`endif

endmodule
